FILE: rtl/core/sbm_pkg.sv
// Shared types and constants of the symmetric bit matrix.
package sbm_pkg;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 6;
  localparam int CFG_W   = 7;
  localparam int COUNT_W = 13;

  localparam logic [CMD_W-1:0] CMD_TEST_SET = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESET    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GET      = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd3;

  localparam logic [CFG_W-1:0] WIDTH_RESET = 7'd64;

  // controller -> datapath
  typedef struct packed {
    logic latch;        // capture the input item
    logic rd;           // read both mirror words
    logic wr_first;     // write back the word of (row,col), update counts
    logic wr_second;    // write back the word of (col,row)
    logic sweep_start;  // restart the clearing pass, zero the counts
    logic sweep_step;   // zero one word, advance
    logic load_out;     // load the result register
  } sbm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_clear;
    logic out_range;
    logic change;
    logic split;
    logic sweep_last;
  } sbm_stat_t;

endpackage

FILE: rtl/core/sbm_ctrl.sv
// Sequencer for the symmetric bit matrix: item steps, clearing pass, result slot.
module sbm_ctrl
  import sbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      cfg_write,
  input  logic      out_ready,
  output logic      out_valid,
  input  sbm_stat_t stat,
  output sbm_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_MODIFY = 3'd2;
  localparam logic [2:0] ST_WRITE2 = 3'd3;
  localparam logic [2:0] ST_SWEEP  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       report;
  logic       report_next;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && !cfg_write;

  always_comb begin
    state_next  = state;
    report_next = report;
    cmd         = '0;
    if (cfg_write) begin
      // a new width wipes the store; no result is owed
      cmd.sweep_start = 1'b1;
      report_next     = 1'b0;
      state_next      = ST_SWEEP;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd.latch  = 1'b1;
            state_next = ST_READ;
          end
        end
        ST_READ: begin
          if (stat.is_clear) begin
            cmd.sweep_start = 1'b1;
            report_next     = 1'b1;
            state_next      = ST_SWEEP;
          end else if (stat.out_range) begin
            state_next = ST_FINISH;
          end else begin
            cmd.rd     = 1'b1;
            state_next = ST_MODIFY;
          end
        end
        ST_MODIFY: begin
          cmd.wr_first = stat.change;
          state_next   = (stat.change && stat.split) ? ST_WRITE2 : ST_FINISH;
        end
        ST_WRITE2: begin
          cmd.wr_second = 1'b1;
          state_next    = ST_FINISH;
        end
        ST_SWEEP: begin
          cmd.sweep_step = 1'b1;
          if (stat.sweep_last) begin
            state_next = report ? ST_FINISH : ST_IDLE;
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            cmd.load_out = 1'b1;
            state_next   = ST_IDLE;
          end
        end
        default: begin
          state_next = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      report    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      report <= report_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> slot_free)
    else $error("result register overwritten while full");

  a_item_ends_in_finish: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE2 && !cfg_write) |=> state == ST_FINISH)
    else $error("second write not followed by result");

  a_no_accept_during_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> !in_ready)
    else $error("input taken during clearing pass");

endmodule

FILE: rtl/core/sbm_datapath.sv
// Bit store, mirror addressing, running counts and result register.
module sbm_datapath
  import sbm_pkg::*;
#(
  parameter int MAX_WIDTH = 64,
  parameter int WORD_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  sbm_cmd_t           cmd,
  output sbm_stat_t          stat,
  input  logic [CFG_W-1:0]   matrix_width,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [IDX_W-1:0]   in_row,
  input  logic [IDX_W-1:0]   in_col,
  output logic               prev_bit,
  output logic [COUNT_W-1:0] set_count,
  output logic               empty_flag,
  output logic               ident_flag,
  output logic               out_of_range
);

  localparam int IDX_BITS   = $clog2(MAX_WIDTH);
  localparam int LIN_BITS   = 2 * IDX_BITS;
  // a word holds the largest power-of-two count of bits that fits in it
  localparam int LOG_LANE   = $clog2(WORD_BITS + 1) - 1;
  localparam int BIT_SEL    = (LOG_LANE < LIN_BITS) ? LOG_LANE : LIN_BITS - 1;
  localparam int WADDR_BITS = LIN_BITS - BIT_SEL;
  localparam int DEPTH      = 2 ** WADDR_BITS;
  localparam int CNT_BITS   = $clog2(MAX_WIDTH * MAX_WIDTH + 1);
  localparam int DIAG_BITS  = $clog2(MAX_WIDTH + 1);

  logic [WORD_BITS-1:0]  mem [DEPTH];
  logic [CMD_W-1:0]      lat_cmd;
  logic [IDX_W-1:0]      lat_row;
  logic [IDX_W-1:0]      lat_col;
  logic [WORD_BITS-1:0]  rdata_a;
  logic [WORD_BITS-1:0]  rdata_b;
  logic [WADDR_BITS-1:0] sweep_addr;
  logic [CNT_BITS-1:0]   total;
  logic [DIAG_BITS-1:0]  diag_total;

  logic [CFG_W-1:0]      n;
  logic [LIN_BITS-1:0]   lin_a;
  logic [LIN_BITS-1:0]   lin_b;
  logic [WADDR_BITS-1:0] waddr_a;
  logic [WADDR_BITS-1:0] waddr_b;
  logic [WORD_BITS-1:0]  mask_a;
  logic [WORD_BITS-1:0]  mask_b;
  logic [WORD_BITS-1:0]  mask_first;
  logic [WORD_BITS-1:0]  wdata_a;
  logic [WORD_BITS-1:0]  wdata_b;
  logic                  wr_en;
  logic [WADDR_BITS-1:0] wr_addr;
  logic [WORD_BITS-1:0]  wr_data;
  logic                  do_set;
  logic                  diag;
  logic                  prev;
  logic [CNT_BITS-1:0]   step;

  // saturate the configured width to the store size
  assign n = (MAX_WIDTH < 128 && matrix_width > CFG_W'(MAX_WIDTH)) ?
             CFG_W'(MAX_WIDTH) : matrix_width;

  assign lin_a   = {IDX_BITS'(lat_row), IDX_BITS'(lat_col)};
  assign lin_b   = {IDX_BITS'(lat_col), IDX_BITS'(lat_row)};
  assign waddr_a = lin_a[LIN_BITS-1:BIT_SEL];
  assign waddr_b = lin_b[LIN_BITS-1:BIT_SEL];
  assign mask_a  = WORD_BITS'(1) << lin_a[BIT_SEL-1:0];
  assign mask_b  = WORD_BITS'(1) << lin_b[BIT_SEL-1:0];

  assign do_set     = (lat_cmd == CMD_TEST_SET);
  assign diag       = (lat_row == lat_col);
  assign prev       = |(rdata_a & mask_a);
  assign stat.split = (waddr_a != waddr_b);
  // both bits in one word: touch them in the first write
  assign mask_first = stat.split ? mask_a : (mask_a | mask_b);
  assign wdata_a    = do_set ? (rdata_a | mask_first) : (rdata_a & ~mask_first);
  assign wdata_b    = do_set ? (rdata_b | mask_b) : (rdata_b & ~mask_b);
  assign step       = diag ? CNT_BITS'(1) : CNT_BITS'(2);

  assign stat.is_clear   = (lat_cmd == CMD_CLEAR);
  assign stat.out_range  = ({1'b0, lat_row} >= n) || ({1'b0, lat_col} >= n);
  assign stat.change     = (do_set && !prev) || ((lat_cmd == CMD_RESET) && prev);
  assign stat.sweep_last = (sweep_addr == WADDR_BITS'(DEPTH - 1));

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = waddr_a;
    wr_data = wdata_a;
    if (cmd.sweep_step) begin
      wr_addr = sweep_addr;
      wr_data = '0;
    end else if (cmd.wr_second) begin
      wr_addr = waddr_b;
      wr_data = wdata_b;
    end else if (!cmd.wr_first) begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rdata_a <= mem[waddr_a];
      rdata_b <= mem[waddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lat_cmd <= in_cmd;
      lat_row <= in_row;
      lat_col <= in_col;
    end
    if (cmd.load_out) begin
      prev_bit     <= prev && !stat.is_clear && !stat.out_range;
      set_count    <= COUNT_W'(total);
      empty_flag   <= (total == '0);
      ident_flag   <= (total == CNT_BITS'(n)) && (diag_total == DIAG_BITS'(n));
      out_of_range <= stat.out_range && !stat.is_clear;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      total      <= '0;
      diag_total <= '0;
    end else begin
      if (cmd.sweep_start) begin
        sweep_addr <= '0;
        total      <= '0;
        diag_total <= '0;
      end else begin
        if (cmd.sweep_step) begin
          sweep_addr <= sweep_addr + WADDR_BITS'(1);
        end
        if (cmd.wr_first) begin
          if (do_set) begin
            total      <= total + step;
            diag_total <= diag_total + DIAG_BITS'(diag);
          end else begin
            total      <= total - step;
            diag_total <= diag_total - DIAG_BITS'(diag);
          end
        end
      end
    end
  end

  a_diag_within_total: assert property (@(posedge clk) disable iff (rst)
    CNT_BITS'(diag_total) <= total)
    else $error("diagonal count exceeds total count");

  // off-diagonal bits come in mirror pairs
  a_pair_parity: assert property (@(posedge clk) disable iff (rst)
    total[0] == diag_total[0])
    else $error("total and diagonal counts disagree in parity");

  a_no_read_on_write: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> !(cmd.sweep_step || cmd.wr_first || cmd.wr_second))
    else $error("read issued together with a store write");

endmodule

FILE: rtl/core/symmetric_bit_matrix_top.sv
// Top level of the symmetric bit matrix: ports, width register, controller and datapath.
//
//   channel   direction  signals                               carries
//   s_axis    in         tvalid tready tdata[15:0] tuser[1:0]  command items
//   m_axis    out        tvalid tready tdata[15:0] tuser       result items
//   cfg       in         valid ready data[6:0]                 matrix width writes
//
// An item out of range steps idle, read, finish; get, a no-op change or a change in one
// word steps idle, read, modify, finish; a second write step follows when the mirror bit
// sits in another word (two writes on the single store write port); clear all sweeps
// DEPTH words (one word a cycle) before finish. After reset and after every width write a
// clearing pass of DEPTH words (64 with the default parameters) keeps s_axis_tready low.
// A finished result waits in the output register; a full register stalls only the
// last step of the following item.
module symmetric_bit_matrix_top
  import sbm_pkg::*;
#(
  parameter int MAX_WIDTH = 64,
  parameter int WORD_BITS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,   // row[5:0], col[11:6], zero[15:12]
  input  logic [1:0]       s_axis_tuser,   // cmd[1:0]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // prev_bit[0], set_count[13:1], empty_flag[14],
                                           // ident_flag[15]
  output logic             m_axis_tuser,   // out_of_range
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [CFG_W-1:0]   matrix_width;
  logic               cfg_write;
  sbm_cmd_t           cmd;
  sbm_stat_t          stat;
  logic               prev_bit;
  logic [COUNT_W-1:0] set_count;
  logic               empty_flag;
  logic               ident_flag;
  logic               out_of_range;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_width <= WIDTH_RESET;
    end else if (cfg_write) begin
      matrix_width <= cfg_data;
    end
  end

  sbm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .cfg_write (cfg_write),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .stat      (stat),
    .cmd       (cmd)
  );

  sbm_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .matrix_width (matrix_width),
    .in_cmd       (s_axis_tuser),
    .in_row       (s_axis_tdata[5:0]),
    .in_col       (s_axis_tdata[11:6]),
    .prev_bit     (prev_bit),
    .set_count    (set_count),
    .empty_flag   (empty_flag),
    .ident_flag   (ident_flag),
    .out_of_range (out_of_range)
  );

  assign m_axis_tdata = {ident_flag, empty_flag, set_count, prev_bit};
  assign m_axis_tuser = out_of_range;

endmodule
